// ----- src/ugli_pkg.sv -----
// constants and codes for the uniform grid lagrange interpolator
// no dependencies; imported by uniform_grid_lagrange_interp_top
`default_nettype none

package ugli_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS   = 30;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_GRID_SPACING = 2'd1;
    localparam logic [1:0] CFG_INTERP_MODE  = 2'd2;

    // interpolation modes
    localparam logic [1:0] MODE_P4 = 2'd0;
    localparam logic [1:0] MODE_P5 = 2'd1;
    localparam logic [1:0] MODE_E4 = 2'd2;
    localparam logic [1:0] MODE_E5 = 2'd3;

    // input action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic signed [63:0] ACC_LIM = 64'sd1 <<< 62;

endpackage

`default_nettype wire

// ----- src/uniform_grid_lagrange_interp_top.sv -----
// uniform grid lagrange interpolator: sample table, serial divider and horner sequencer
// depends on ugli_pkg
//
//  channel   dir  signals                              payload
//  s_axis    in   s_axis_tvalid/tready/tdata/tuser     index, value, position / action
//  m_axis    out  m_axis_tvalid/tready/tdata/tuser     interp_value / saturated
//  cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data      register write
//
// a query runs from its accepting edge to a valid result through 32 steps of the serial
// divider for x / dr, 30 more for the fraction, the table reads, the difference passes, then
// per horner step a multiply and, for the divide by three, a second multiply by the
// reciprocal. the input is not ready while a query runs; a finished result waits in the
// output register and the next beat is taken meanwhile. reset is synchronous and clears
// control only; the table is undefined until written.
`default_nettype none

module uniform_grid_lagrange_interp_top
    import ugli_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [79:0] s_axis_tdata,  // sample_index[9:0], sample_value[41:10], query_position[73:42]
    input  wire         s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,  // interp_value[31:0]
    output logic        m_axis_tuser,  // saturated
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_QR    = 4'd2;
    localparam logic [3:0] S_FRAC  = 4'd3;
    localparam logic [3:0] S_SETUP = 4'd4;
    localparam logic [3:0] S_SVAL  = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_DIFF  = 4'd7;
    localparam logic [3:0] S_HINIT = 4'd8;
    localparam logic [3:0] S_HSET  = 4'd9;
    localparam logic [3:0] S_HMUL  = 4'd10;
    localparam logic [3:0] S_HRND  = 4'd11;
    localparam logic [3:0] S_D3    = 4'd12;
    localparam logic [3:0] S_HACC  = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    localparam logic [63:0] MAG_LIM = 64'd1 << 62;
    localparam logic [63:0] RCP3    = 64'hAAAA_AAAA_AAAA_AAAB;

    // configuration
    logic [10:0] r_sample_count;
    logic [31:0] r_grid_spacing;
    logic [1:0]  r_interp_mode;

    logic [3:0]  r_state;
    logic [6:0]  r_cnt;

    // shared restoring divider
    logic [63:0] r_sh;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic        r_xneg;
    logic [32:0] w_t;
    logic [33:0] w_diff;
    logic        w_ge;

    logic signed [34:0] r_q;
    logic signed [34:0] r_j0;
    logic [2:0]         r_d;
    logic               r_mir;
    logic signed [63:0] r_s;
    logic [2:0]         r_t;
    logic [2:0]         r_di;
    logic [2:0]         r_ci;
    logic [2:0]         r_k;
    logic signed [36:0] r_c [5];

    logic signed [63:0] r_acc;
    logic [63:0]        r_ma;
    logic [63:0]        r_mf;
    logic               r_neg;
    logic               r_rcp;
    logic [127:0]       r_prod;
    logic [63:0]        r_mag;

    logic [31:0] r_mem [TABLE_DEPTH];
    logic [31:0] r_rdata;

    logic [31:0] r_out_val;
    logic        r_out_sat;
    logic        r_out_valid;

    logic [31:0] w_dr_eff;
    logic [10:0] w_n;
    logic signed [34:0] w_nn;
    logic [31:0] w_xabs;
    logic signed [31:0] w_x;
    logic w_in_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_x       = signed'(s_axis_tdata[73:42]);
    assign w_xabs    = w_x[31] ? (32'd0 - s_axis_tdata[73:42]) : s_axis_tdata[73:42];
    assign w_dr_eff  = (r_grid_spacing == 32'd0) ? 32'd1 : r_grid_spacing;
    assign w_n       = (r_sample_count > 11'(TABLE_DEPTH)) ? 11'(TABLE_DEPTH) : r_sample_count;
    assign w_nn      = signed'({24'd0, w_n});

    assign w_t    = {r_rem, r_sh[63]};
    assign w_diff = {1'b0, w_t} - {2'b00, r_dvs};
    assign w_ge   = ~w_diff[33];

    // stencil choice
    logic [2:0]         w_d;
    logic signed [34:0] w_j0;
    logic               w_mir;
    always_comb begin
        logic signed [34:0] base;
        logic signed [34:0] hi;
        w_d   = 3'd1;
        w_mir = 1'b0;
        base  = r_q;
        hi    = w_nn - 35'sd2;
        if (w_n == 11'd1) begin
            w_d  = 3'd0;
            base = '0;
            hi   = '0;
        end else if (w_n < 11'd4) begin
            w_d  = 3'd1;
            base = r_q;
            hi   = w_nn - 35'sd2;
        end else begin
            w_mir = r_interp_mode[1];
            if ((r_interp_mode == MODE_P5 || r_interp_mode == MODE_E5) && w_n >= 11'd5) begin
                w_d  = 3'd4;
                base = r_q - 35'sd2;
                hi   = w_nn - 35'sd5;
            end else begin
                w_d  = 3'd3;
                base = r_q - 35'sd1;
                hi   = w_nn - 35'sd4;
            end
        end
        w_j0 = base;
        if (!w_mir && w_j0 < 0) begin
            w_j0 = '0;
        end
        if (w_j0 > hi) begin
            w_j0 = hi;
        end
    end

    // read address of stencil node r_t, mirrored in even modes
    logic signed [34:0] w_j;
    logic signed [34:0] w_ja;
    logic [ADDR_W-1:0]  w_addr;
    always_comb begin
        w_j  = r_j0 + signed'({32'd0, r_t});
        w_ja = (r_mir && w_j < 0) ? -w_j : w_j;
        if (r_mir && w_ja >= w_nn) begin
            w_ja = w_nn - 35'sd1;
        end
        w_addr = w_ja[ADDR_W-1:0];
    end

    // horner helpers
    logic signed [63:0] w_fac;
    logic [63:0]        w_pp;
    logic [6:0]         w_shamt;
    logic [127:0]       w_p;
    logic [63:0]        w_val;
    logic [63:0]        w_mag_l;
    logic signed [63:0] w_sp;
    logic signed [63:0] w_sum;
    logic signed [63:0] w_sval;

    assign w_fac   = r_s - (signed'({61'd0, r_k - 3'd1}) <<< FRAC_BITS);
    assign w_pp    = 64'(r_ma[{r_cnt[0], 5'd0} +: 32]) * 64'(r_mf[{r_cnt[1], 5'd0} +: 32]);
    assign w_shamt = {({1'b0, r_cnt[0]} + {1'b0, r_cnt[1]}), 5'd0};
    assign w_p     = r_prod + (128'(r_k) << (FRAC_BITS - 1));
    assign w_val   = w_p[FRAC_BITS+63:FRAC_BITS];
    assign w_mag_l = (r_mag > MAG_LIM) ? MAG_LIM : r_mag;
    assign w_sp    = r_neg ? -signed'(w_mag_l) : signed'(w_mag_l);
    assign w_sum   = 64'(r_c[r_ci]) + w_sp;
    assign w_sval  = (64'(r_q - r_j0) <<< FRAC_BITS) + signed'({34'd0, r_sh[FRAC_BITS-1:0]});

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_val;
    assign m_axis_tuser  = r_out_sat;

    // sample table
    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tuser == ACT_WRITE) begin
            r_mem[s_axis_tdata[ADDR_W-1:0]] <= s_axis_tdata[41:10];
        end
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_grid_spacing <= 32'd65536;
            r_interp_mode  <= MODE_P4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[10:0];
                CFG_GRID_SPACING: r_grid_spacing <= i_cfg_data;
                CFG_INTERP_MODE:  r_interp_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && s_axis_tuser == ACT_QUERY) begin
                        r_sh    <= {w_xabs, 32'd0};
                        r_rem   <= '0;
                        r_dvs   <= w_dr_eff;
                        r_xneg  <= w_x[31];
                        r_cnt   <= 7'd32;
                        r_state <= S_DIV;
                    end
                end
                S_DIV, S_FRAC: begin
                    r_rem <= w_ge ? w_diff[31:0] : w_t[31:0];
                    r_sh  <= {r_sh[62:0], w_ge};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        case (r_state)
                            S_DIV:   r_state <= S_QR;
                            default: r_state <= S_SETUP;
                        endcase
                    end
                end
                S_QR: begin
                    // floor division for negative positions
                    if (r_xneg && r_rem != 32'd0) begin
                        r_q   <= -signed'({3'd0, r_sh[31:0]}) - 35'sd1;
                        r_rem <= r_dvs - r_rem;
                    end else if (r_xneg) begin
                        r_q <= -signed'({3'd0, r_sh[31:0]});
                    end else begin
                        r_q <= signed'({3'd0, r_sh[31:0]});
                    end
                    r_sh    <= '0;
                    r_cnt   <= 7'(FRAC_BITS);
                    r_state <= S_FRAC;
                end
                S_SETUP: begin
                    r_d   <= w_d;
                    r_j0  <= w_j0;
                    r_mir <= w_mir;
                    if (w_n == 11'd0) begin
                        r_acc   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SVAL;
                    end
                end
                S_SVAL: begin
                    r_s     <= w_sval;
                    r_t     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    // read data arrives in the cycle after its address
                    for (int i = 0; i < 5; i++) begin
                        if (r_t != 3'd0 && 3'(i) == r_t - 3'd1) begin
                            r_c[i] <= 37'(signed'(r_rdata));
                        end
                    end
                    r_t <= r_t + 3'd1;
                    if (r_t == r_d + 3'd1) begin
                        r_di    <= 3'd1;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    if (r_di > r_d) begin
                        r_ci    <= r_d;
                        r_state <= S_HINIT;
                    end else begin
                        for (int i = 1; i < 5; i++) begin
                            if (3'(i) >= r_di && 3'(i) <= r_d) begin
                                r_c[i] <= r_c[i] - r_c[i-1];
                            end
                        end
                        r_di <= r_di + 3'd1;
                    end
                end
                S_HINIT: begin
                    r_acc <= 64'(r_c[r_ci]);
                    r_k   <= r_d;
                    r_ci  <= r_d - 3'd1;
                    r_state <= (r_d == 3'd0) ? S_FIN : S_HSET;
                end
                S_HSET: begin
                    r_ma    <= r_acc[63] ? 64'd0 - r_acc : r_acc;
                    r_mf    <= w_fac[63] ? 64'd0 - w_fac : w_fac;
                    r_neg   <= r_acc[63] ^ w_fac[63];
                    r_rcp   <= 1'b0;
                    r_prod  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_HMUL;
                end
                S_HMUL: begin
                    r_prod <= r_prod + ({64'd0, w_pp} << w_shamt);
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_state <= r_rcp ? S_D3 : S_HRND;
                    end
                end
                S_HRND: begin
                    if (|w_p[127:FRAC_BITS+64]) begin
                        r_mag   <= MAG_LIM;
                        r_state <= S_HACC;
                    end else begin
                        case (r_k)
                            3'd2: begin
                                r_mag   <= w_val >> 1;
                                r_state <= S_HACC;
                            end
                            3'd3: begin
                                // divide by three as a multiply by ceil(2^65 / 3)
                                r_ma    <= w_val;
                                r_mf    <= RCP3;
                                r_rcp   <= 1'b1;
                                r_prod  <= '0;
                                r_cnt   <= '0;
                                r_state <= S_HMUL;
                            end
                            3'd4: begin
                                r_mag   <= w_val >> 2;
                                r_state <= S_HACC;
                            end
                            default: begin
                                r_mag   <= w_val;
                                r_state <= S_HACC;
                            end
                        endcase
                    end
                end
                S_D3: begin
                    r_mag   <= 64'(r_prod[127:65]);
                    r_state <= S_HACC;
                end
                S_HACC: begin
                    if (w_sum > ACC_LIM) begin
                        r_acc <= ACC_LIM;
                    end else if (w_sum < -ACC_LIM) begin
                        r_acc <= -ACC_LIM;
                    end else begin
                        r_acc <= w_sum;
                    end
                    r_k  <= r_k - 3'd1;
                    r_ci <= r_ci - 3'd1;
                    r_state <= (r_k == 3'd1) ? S_FIN : S_HSET;
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        if (r_acc > 64'sd2147483647) begin
                            r_out_val <= 32'h7FFF_FFFF;
                            r_out_sat <= 1'b1;
                        end else if (r_acc < -64'sd2147483648) begin
                            r_out_val <= 32'h8000_0000;
                            r_out_sat <= 1'b1;
                        end else begin
                            r_out_val <= r_acc[31:0];
                            r_out_sat <= 1'b0;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE)
        else $error("input ready outside idle");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tuser == ACT_QUERY) |=> !s_axis_tready)
        else $error("query did not start the sequencer");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000))
        else $error("saturation flag without a clipped value");

    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HSET) |-> (r_acc <= ACC_LIM && r_acc >= -ACC_LIM))
        else $error("horner accumulator out of range");
`endif

endmodule

`default_nettype wire
